// File: hw/rtl/v3n_pkg.sv
package v3n_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned SumW   = 2 * CompW;
  localparam int unsigned RemW   = CompW + 3;
  localparam int unsigned QuotW  = 31;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned SqCells  = SumW / 2;
  localparam int unsigned DivCells = QuotW;

  // Beat moving down the square-root row.
  typedef struct packed {
    logic                          vld;
    logic [SumW-1:0]               n;
    logic [RemW-1:0]               rem;
    logic [CompW-1:0]              root;
    logic [Lanes-1:0][CompW-1:0]   mag;
    logic [Lanes-1:0]              neg;
  } sq_beat_t;

  // Beat moving down the divider row, three lanes side by side.
  typedef struct packed {
    logic                          vld;
    logic [CompW-1:0]              len;
    logic [Lanes-1:0]              neg;
    logic [Lanes-1:0][CompW-1:0]   rem;
    logic [Lanes-1:0][QuotW-1:0]   quot;
    logic [Lanes-1:0]              dbit;
  } div_beat_t;

endpackage

// File: hw/rtl/vector3_normalize_core.sv
// The pipeline holds a square stage, a sum stage, 32 root cells, 31 divider
// cells and an output stage.
// Throughput: one vector per cycle; busy_o is never raised.
// Each result is shown for one cycle with done_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; data is not reset.
module vector3_normalize_core
  import v3n_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [CompW-1:0] comp_x_i,
  input  logic signed [CompW-1:0] comp_y_i,
  input  logic signed [CompW-1:0] comp_z_i,
  output logic                    done_o,
  output logic signed [CompW-1:0] unit_x_o,
  output logic signed [CompW-1:0] unit_y_o,
  output logic signed [CompW-1:0] unit_z_o,
  output logic        [CompW-1:0] length_o,
  output logic                    zero_length_o
);

  logic [Lanes-1:0][CompW-1:0] comp;
  logic [Lanes-1:0][CompW-1:0] mag_d;
  logic [Lanes-1:0]            neg_d;

  logic                        s1_vld_q;
  logic [Lanes-1:0][CompW-1:0] s1_mag_q;
  logic [Lanes-1:0]            s1_neg_q;
  logic [Lanes-1:0][SumW-1:0]  s1_sq_q;

  logic                        s2_vld_q;
  logic [Lanes-1:0][CompW-1:0] s2_mag_q;
  logic [Lanes-1:0]            s2_neg_q;
  logic [SumW-1:0]             s2_sum_q;

  sq_beat_t  sq_chain  [SqCells+1];
  div_beat_t div_chain [DivCells+1];

  logic                        out_vld_q;
  logic [Lanes-1:0][CompW-1:0] unit_q;
  logic [CompW-1:0]            len_q;
  logic                        zero_q;

  assign busy_o = 1'b0;
  assign comp   = {comp_z_i, comp_y_i, comp_x_i};

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      neg_d[l] = comp[l][CompW-1];
      mag_d[l] = neg_d[l] ? (~comp[l] + 1'b1) : comp[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= div_chain[DivCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      s1_sq_q[l] <= mag_d[l] * mag_d[l];
    end
    s1_mag_q <= mag_d;
    s1_neg_q <= neg_d;
    s2_sum_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    s2_mag_q <= s1_mag_q;
    s2_neg_q <= s1_neg_q;
  end

  always_comb begin
    sq_chain[0].vld  = s2_vld_q;
    sq_chain[0].n    = s2_sum_q;
    sq_chain[0].rem  = '0;
    sq_chain[0].root = '0;
    sq_chain[0].mag  = s2_mag_q;
    sq_chain[0].neg  = s2_neg_q;
  end

  for (genvar c = 0; c < SqCells; c++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (sq_chain[c]),
      .beat_o (sq_chain[c+1])
    );
  end

  // The dividend is mag * 2^30; its upper part mag >> 1 seeds the remainder
  // and the low bit of mag enters in the first divider cell.
  always_comb begin
    div_chain[0].vld = sq_chain[SqCells].vld;
    div_chain[0].len = sq_chain[SqCells].root;
    div_chain[0].neg = sq_chain[SqCells].neg;
    for (int l = 0; l < Lanes; l++) begin
      div_chain[0].rem[l]  = {1'b0, sq_chain[SqCells].mag[l][CompW-1:1]};
      div_chain[0].quot[l] = '0;
      div_chain[0].dbit[l] = sq_chain[SqCells].mag[l][0];
    end
  end

  for (genvar c = 0; c < DivCells; c++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (div_chain[c]),
      .beat_o (div_chain[c+1])
    );
  end

  always_ff @(posedge clk_i) begin
    zero_q <= (div_chain[DivCells].len == '0);
    len_q  <= div_chain[DivCells].len;
    for (int l = 0; l < Lanes; l++) begin
      if (div_chain[DivCells].len == '0) begin
        unit_q[l] <= '0;
      end else if (div_chain[DivCells].neg[l]) begin
        unit_q[l] <= ~{1'b0, div_chain[DivCells].quot[l]} + 1'b1;
      end else begin
        unit_q[l] <= {1'b0, div_chain[DivCells].quot[l]};
      end
    end
  end

  assign done_o        = out_vld_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign length_o      = len_q;
  assign zero_length_o = zero_q;

  a_zero_outputs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_length_o |-> length_o == '0 && unit_x_o == '0 &&
                                unit_y_o == '0 && unit_z_o == '0)
    else $error("zero vector with nonzero outputs");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> unit_x_o <= 32'sd1073741824 && unit_x_o >= -32'sd1073741824 &&
               unit_y_o <= 32'sd1073741824 && unit_y_o >= -32'sd1073741824)
    else $error("unit component beyond 1.0");

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##66 done_o)
    else $error("beat lost in pipeline");

endmodule

// File: hw/rtl/v3n_sqrt_cell.sv
module v3n_sqrt_cell
  import v3n_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sq_beat_t beat_i,
  output sq_beat_t beat_o
);

  logic [RemW-1:0] part;
  logic [RemW-1:0] trial;
  logic            ge;
  logic            vld_q;
  sq_beat_t        beat_d, beat_q;

  // One result bit per cell: bring down two radicand bits and try 4r+1.
  always_comb begin
    part   = {beat_i.rem[RemW-3:0], beat_i.n[SumW-1 -: 2]};
    trial  = {1'b0, beat_i.root, 2'b01};
    ge     = (part >= trial);
    beat_d = beat_i;
    beat_d.rem  = ge ? (part - trial) : part;
    beat_d.root = {beat_i.root[CompW-2:0], ge};
    beat_d.n    = {beat_i.n[SumW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  // Only the valid bit is reset; the data fields pass through unreset.
  always_comb begin
    beat_o     = beat_q;
    beat_o.vld = vld_q;
  end

endmodule

// File: hw/rtl/v3n_div_cell.sv
module v3n_div_cell
  import v3n_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_beat_t beat_i,
  output div_beat_t beat_o
);

  logic [CompW:0] part [Lanes];
  logic           ge   [Lanes];
  logic           vld_q;
  div_beat_t      beat_d, beat_q;

  // One quotient bit per lane; the remainder stays below the length when it is nonzero.
  always_comb begin
    beat_d = beat_i;
    for (int l = 0; l < Lanes; l++) begin
      part[l] = {beat_i.rem[l], beat_i.dbit[l]};
      ge[l]   = (part[l] >= {1'b0, beat_i.len});
      beat_d.rem[l]  = ge[l] ? CompW'(part[l] - {1'b0, beat_i.len}) : part[l][CompW-1:0];
      beat_d.quot[l] = {beat_i.quot[l][QuotW-2:0], ge[l]};
    end
    beat_d.dbit = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  // Only the valid bit is reset; the data fields pass through unreset.
  always_comb begin
    beat_o     = beat_q;
    beat_o.vld = vld_q;
  end

endmodule

// File: test/vector3_normalize_core_tb.sv
module vector3_normalize_core_tb;
  import v3n_pkg::*;

  localparam int unsigned Latency   = 66;
  localparam int unsigned NumRandom = 500;
  localparam int unsigned MaxCycles = 200000;

  typedef struct packed {
    logic signed [CompW-1:0] ux;
    logic signed [CompW-1:0] uy;
    logic signed [CompW-1:0] uz;
    logic [CompW-1:0]        len;
    logic                    zero;
  } unit_vec_t;

  typedef struct {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic                    has_known;
    unit_vec_t               known;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [CompW-1:0] comp_x_i = '0;
  logic signed [CompW-1:0] comp_y_i = '0;
  logic signed [CompW-1:0] comp_z_i = '0;
  logic busy_o, done_o, zero_length_o;
  logic signed [CompW-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic [CompW-1:0] length_o;

  unit_vec_t pending_units[$];
  vec_row_t  dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic idle_enable = 1'b1;

  always #5 clk_i = ~clk_i;

  vector3_normalize_core i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .comp_x_i, .comp_y_i, .comp_z_i,
    .done_o, .unit_x_o, .unit_y_o, .unit_z_o, .length_o, .zero_length_o
  );

  function automatic logic [63:0] floor_root(logic [65:0] n);
    logic [65:0] res, bit_v;
    res = '0;
    bit_v = 66'd1 << 64;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[63:0];
  endfunction

  function automatic unit_vec_t normalize(logic signed [CompW-1:0] x,
                                          logic signed [CompW-1:0] y,
                                          logic signed [CompW-1:0] z);
    logic [CompW:0] mag [3];
    logic           neg [3];
    logic [65:0]    sum;
    logic [63:0]    len;
    logic [63:0]    q;
    logic [CompW-1:0] res [3];
    unit_vec_t      u;
    mag[0] = x[CompW-1] ? 33'h1_0000_0000 - {1'b0, x} : {1'b0, x};
    mag[1] = y[CompW-1] ? 33'h1_0000_0000 - {1'b0, y} : {1'b0, y};
    mag[2] = z[CompW-1] ? 33'h1_0000_0000 - {1'b0, z} : {1'b0, z};
    neg[0] = x[CompW-1];
    neg[1] = y[CompW-1];
    neg[2] = z[CompW-1];
    sum = '0;
    for (int i = 0; i < 3; i++) sum += 66'(mag[i]) * 66'(mag[i]);
    len = floor_root(sum);
    u = '0;
    if (len == 0) begin
      u.zero = 1'b1;
      return u;
    end
    for (int i = 0; i < 3; i++) begin
      q = (64'(mag[i]) << 30) / len;
      res[i] = neg[i] ? 32'(-q) : q[31:0];
    end
    u.ux = res[0];
    u.uy = res[1];
    u.uz = res[2];
    u.len = len[31:0];
    return u;
  endfunction

  // Results can't be held off, so check each strobed beat as it arrives.
  always @(posedge clk_i) begin
    unit_vec_t got, want;
    if (rst_ni && done_o) begin
      got = '{unit_x_o, unit_y_o, unit_z_o, length_o, zero_length_o};
      if (pending_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_units.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_vector(logic signed [CompW-1:0] x, logic signed [CompW-1:0] y,
                             logic signed [CompW-1:0] z, logic has_known,
                             unit_vec_t known);
    unit_vec_t want;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    comp_x_i <= x;
    comp_y_i <= y;
    comp_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    want = normalize(x, y, z);
    if (has_known && known !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("table row %p disagrees with %p", known, want);
    end
    pending_units.push_back(want);
  endtask

  function automatic logic signed [CompW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      1: return 32'($signed($urandom_range(0, 512)) - 256);
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    unit_vec_t none;
    int unsigned waited;
    none = '0;
    dir_rows.push_back('{0, 0, 0, 1, '{0, 0, 0, 0, 1}});
    dir_rows.push_back('{32'sh10000, 0, 0, 1, '{32'sh4000_0000, 0, 0, 32'h10000, 0}});
    dir_rows.push_back('{0, -32'sh10000, 0, 1, '{0, -32'sh4000_0000, 0, 32'h10000, 0}});
    dir_rows.push_back('{0, 0, 1, 1, '{0, 0, 32'sh4000_0000, 1, 0}});
    dir_rows.push_back('{32'sh8000_0000, 0, 0, 1,
                         '{32'sh c000_0000, 0, 0, 32'h8000_0000, 0}});
    dir_rows.push_back('{0, 0, 32'sh7fff_ffff, 1,
                         '{0, 0, 32'sh4000_0000, 32'h7fff_ffff, 0}});
    dir_rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, none});
    dir_rows.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, none});
    dir_rows.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, none});
    dir_rows.push_back('{3, 4, 0, 0, none});
    dir_rows.push_back('{-1, -1, -1, 0, none});
    dir_rows.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, -7, 0, none});
    dir_rows.push_back('{1, -1, 0, 0, none});
    dir_rows.push_back('{-32'sh30000, 32'sh40000, -32'sh c0000, 0, none});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].has_known, dir_rows[i].known);
    for (int i = 0; i < NumRandom; i++) begin
      // The final stretch runs back to back.
      if (i == NumRandom - 100) idle_enable = 1'b0;
      send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, none);
    end
    start_i <= 1'b0;

    waited = 0;
    while (pending_units.size() != 0 && waited < 4 * Latency) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency) @(posedge clk_i);
    if (mismatches == 0 && pending_units.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
